FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, quiet while in reset
`define SDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define SDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SDL_ASSERT(lbl, ante |=> cons, msg)

`endif

FILE: design/sdl_pkg.sv
package sdl_pkg;

  localparam int unsigned MAX_PARTS = 8;
  localparam int unsigned IDX_W     = $clog2(MAX_PARTS);
  localparam int unsigned CNT_W     = IDX_W + 1;

  localparam logic [CNT_W-1:0] PARTS_CNT = CNT_W'(MAX_PARTS);

  localparam logic [15:0] LABEL_MAGIC = 16'hDABE;

  localparam logic [7:0] W_TRACKS  = 8'd218;
  localparam logic [7:0] W_SECTORS = 8'd219;
  localparam logic [7:0] W_PARTS   = 8'd222;
  localparam logic [7:0] W_MAGIC   = 8'd254;
  localparam logic [7:0] W_LAST    = 8'd255;

  localparam logic [1:0] CFG_BASE_SECTOR = 2'd0;
  localparam logic [1:0] CFG_MAX_SLICES  = 2'd1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_MAGIC = 2'd1,
    STATUS_BAD_SUM   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_OV_LOAD,
    ST_OV_CMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic check;
    logic pi_inc;
    logic scan_mul;
    logic scan_wr;
    logic rd_sel_i;
    logic ov_load;
    logic ov_cmp;
    logic ov_wr;
    logic i_inc;
    logic emit_init;
    logic emit_slice;
    logic emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic last_word;
    logic bad;
    logic pi_end;
    logic raw_len_zero;
    logic at_limit;
    logic n_zero;
    logic i_end;
    logic j_end;
    logic rd_len_zero;
    logic emit_last;
  } dp_stat_t;

endpackage

FILE: design/sdl_ctrl.sv
`include "assert_macros.svh"

module sdl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  sdl_pkg::dp_stat_t stat,
  output sdl_pkg::dp_cmd_t  cmd
);
  import sdl_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && stat.last_word) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.bad) begin
          cmd.emit_status = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (stat.pi_end) begin
          state_nxt = ST_OV_LOAD;
        end else if (stat.raw_len_zero) begin
          cmd.pi_inc = 1'b1;
        end else if (stat.at_limit) begin
          state_nxt = ST_OV_LOAD;
        end else begin
          cmd.scan_mul = 1'b1;
          cmd.pi_inc   = 1'b1;
          state_nxt    = ST_SCAN_WR;
        end
      end
      ST_SCAN_WR: begin
        cmd.scan_wr = 1'b1;
        state_nxt   = ST_SCAN_RD;
      end
      ST_OV_LOAD: begin
        cmd.rd_sel_i = 1'b1;
        if (stat.i_end) begin
          if (stat.n_zero) begin
            cmd.emit_status = 1'b1;
            state_nxt       = ST_IDLE;
          end else begin
            cmd.emit_init = 1'b1;
            state_nxt     = ST_EMIT;
          end
        end else if (stat.rd_len_zero) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.ov_load = 1'b1;
          state_nxt   = ST_OV_CMP;
        end
      end
      ST_OV_CMP: begin
        if (stat.j_end) begin
          cmd.ov_wr = 1'b1;
          state_nxt = ST_OV_LOAD;
        end else begin
          cmd.ov_cmp = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit_slice = 1'b1;
        if (stat.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SDL_ASSERT_NEXT(a_last_to_check, cmd.accept && stat.last_word, state_r == ST_CHECK, "last word did not start the check")
  `SDL_ASSERT(a_emit_nonempty, state_r == ST_EMIT |-> !stat.n_zero, "slice emit with no slices")
  `SDL_ASSERT(a_wr_after_mul, state_r == ST_SCAN_WR |-> $past(cmd.scan_mul), "slice write without product")

endmodule

FILE: design/sdl_dp.sv
`include "assert_macros.svh"

module sdl_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           in_label_word,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  sdl_pkg::dp_cmd_t      cmd,
  output sdl_pkg::dp_stat_t     stat,
  output logic                  out_strobe,
  output logic [1:0]            out_status,
  output logic                  out_slice_valid,
  output logic [2:0]            out_slot,
  output logic [31:0]           out_start_sector,
  output logic [31:0]           out_size_sectors,
  output logic [3:0]            out_slice_count,
  output logic                  out_last
);
  import sdl_pkg::*;

  logic [31:0] base_r;
  logic [3:0]  maxs_r;

  logic [7:0]  wcnt_r;
  logic [15:0] xor_r;
  logic [15:0] tracks_r;
  logic [15:0] sectors_r;
  logic [15:0] magic_r;
  status_t     status_r, status_nxt;

  logic [31:0] raw_cyl_r [MAX_PARTS];
  logic [31:0] raw_len_r [MAX_PARTS];
  logic [31:0] sl_start_r [MAX_PARTS];
  logic [31:0] sl_len_r [MAX_PARTS];

  logic [31:0] spt_r;
  logic [31:0] prod_r;
  logic [31:0] len_hold_r;
  logic [31:0] cur_start_r;
  logic [31:0] cur_end_r;
  logic        hit_r;

  logic [CNT_W-1:0] pi_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] j_r;

  logic             out_strobe_r;
  logic [1:0]       out_status_r;
  logic             out_slice_valid_r;
  logic [2:0]       out_slot_r;
  logic [31:0]      out_start_r;
  logic [31:0]      out_size_r;
  logic [3:0]       out_count_r;
  logic             out_last_r;

  logic [7:0]       rel;
  logic             in_parts;
  logic [IDX_W-1:0] cap_p;
  logic [15:0]      xor_nxt;
  logic [31:0]      raw_cyl_sel;
  logic [31:0]      raw_len_sel;
  logic [31:0]      prod_nxt;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_start;
  logic [31:0]      rd_len;
  logic [31:0]      rd_end;
  logic [3:0]       limit;
  logic             overlap;

  assign rel      = wcnt_r - W_PARTS;
  assign in_parts = (wcnt_r >= W_PARTS) && (wcnt_r < W_MAGIC);
  assign cap_p    = rel[IDX_W+1:2];
  assign xor_nxt  = xor_r ^ in_label_word;

  always_comb begin
    if (magic_r != LABEL_MAGIC) begin
      status_nxt = STATUS_BAD_MAGIC;
    end else if (xor_nxt != 16'd0) begin
      status_nxt = STATUS_BAD_SUM;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  assign raw_cyl_sel = raw_cyl_r[pi_r[IDX_W-1:0]];
  assign raw_len_sel = raw_len_r[pi_r[IDX_W-1:0]];
  assign prod_nxt    = raw_cyl_sel * spt_r;

  assign rd_idx   = cmd.rd_sel_i ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign rd_start = sl_start_r[rd_idx];
  assign rd_len   = sl_len_r[rd_idx];
  assign rd_end   = rd_start + rd_len;

  assign limit   = (maxs_r > PARTS_CNT) ? PARTS_CNT : maxs_r;
  assign overlap = (j_r != i_r) && (rd_len != 32'd0) && (cur_start_r < rd_start) &&
                   (cur_end_r > rd_start) && (cur_end_r < rd_end);

  always_comb begin
    stat.last_word    = (wcnt_r == W_LAST);
    stat.bad          = (status_r != STATUS_OK);
    stat.pi_end       = (pi_r == PARTS_CNT);
    stat.raw_len_zero = (raw_len_sel == 32'd0);
    stat.at_limit     = (n_r >= limit);
    stat.n_zero       = (n_r == '0);
    stat.i_end        = (i_r == n_r);
    stat.j_end        = (j_r == n_r);
    stat.rd_len_zero  = (rd_len == 32'd0);
    stat.emit_last    = ((j_r + CNT_W'(1)) == n_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= 32'd0;
      maxs_r       <= PARTS_CNT;
      wcnt_r       <= 8'd0;
      xor_r        <= 16'd0;
      tracks_r     <= 16'd0;
      sectors_r    <= 16'd0;
      magic_r      <= 16'd0;
      status_r     <= STATUS_OK;
      pi_r         <= '0;
      n_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      hit_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BASE_SECTOR: base_r <= cfg_data;
          CFG_MAX_SLICES:  maxs_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        wcnt_r <= wcnt_r + 8'd1;
        xor_r  <= (wcnt_r == W_LAST) ? 16'd0 : xor_nxt;
        if (wcnt_r == W_TRACKS) begin
          tracks_r <= in_label_word;
        end
        if (wcnt_r == W_SECTORS) begin
          sectors_r <= in_label_word;
        end
        if (wcnt_r == W_MAGIC) begin
          magic_r <= in_label_word;
        end
        if (wcnt_r == W_LAST) begin
          status_r <= status_nxt;
        end
      end
      if (cmd.check) begin
        pi_r <= '0;
        n_r  <= '0;
        i_r  <= '0;
      end
      if (cmd.pi_inc) begin
        pi_r <= pi_r + CNT_W'(1);
      end
      if (cmd.scan_wr) begin
        n_r <= n_r + CNT_W'(1);
      end
      if (cmd.ov_load) begin
        hit_r <= 1'b0;
        j_r   <= '0;
      end
      if (cmd.ov_cmp) begin
        if (overlap) begin
          hit_r <= 1'b1;
        end
        j_r <= j_r + CNT_W'(1);
      end
      if (cmd.ov_wr || cmd.i_inc) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.emit_init) begin
        j_r <= '0;
      end
      if (cmd.emit_slice) begin
        j_r <= j_r + CNT_W'(1);
      end
      out_strobe_r <= cmd.emit_slice | cmd.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_parts) begin
      if (rel[1]) begin
        if (rel[0]) begin
          raw_len_r[cap_p][15:0] <= in_label_word;
        end else begin
          raw_len_r[cap_p][31:16] <= in_label_word;
        end
      end else begin
        if (rel[0]) begin
          raw_cyl_r[cap_p][15:0] <= in_label_word;
        end else begin
          raw_cyl_r[cap_p][31:16] <= in_label_word;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      spt_r <= 32'(sectors_r) * 32'(tracks_r);
    end
    if (cmd.scan_mul) begin
      prod_r     <= prod_nxt;
      len_hold_r <= raw_len_sel;
    end
    if (cmd.scan_wr) begin
      sl_start_r[n_r[IDX_W-1:0]] <= base_r + prod_r;
      sl_len_r[n_r[IDX_W-1:0]]   <= len_hold_r;
    end else if (cmd.ov_wr && hit_r) begin
      sl_len_r[i_r[IDX_W-1:0]] <= 32'd0;
    end
    if (cmd.ov_load) begin
      cur_start_r <= rd_start;
      cur_end_r   <= rd_end;
    end
    if (cmd.emit_slice) begin
      out_status_r      <= STATUS_OK;
      out_slice_valid_r <= 1'b1;
      out_slot_r        <= j_r[IDX_W-1:0];
      out_start_r       <= rd_start;
      out_size_r        <= rd_len;
      out_count_r       <= n_r;
      out_last_r        <= stat.emit_last;
    end else if (cmd.emit_status) begin
      out_status_r      <= status_r;
      out_slice_valid_r <= 1'b0;
      out_slot_r        <= '0;
      out_start_r       <= 32'd0;
      out_size_r        <= 32'd0;
      out_count_r       <= 4'd0;
      out_last_r        <= 1'b1;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_slice_valid  = out_slice_valid_r;
  assign out_slot         = out_slot_r;
  assign out_start_sector = out_start_r;
  assign out_size_sectors = out_size_r;
  assign out_slice_count  = out_count_r;
  assign out_last         = out_last_r;

  `SDL_ASSERT(a_n_bound, n_r <= PARTS_CNT, "found count above partition count")
  `SDL_ASSERT(a_status_last, out_strobe_r && !out_slice_valid_r |-> out_last_r, "status item not last")

endmodule

FILE: design/sun_disk_label_parser.sv
// Throughput: 256 label words at one per cycle while busy is low, then one busy stretch.
// Busy after the 256th word: only the check on bad magic or checksum, else the check, then a scan
//   of the partitions that lists n slices, the overlap pass over them and their emit; the scan
//   skips empty partitions and stops at the slice limit or after the eighth partition.
// Results: one per cycle, no backpressure, each the cycle after its emit cycle; a bad magic or
//   checksum status is emitted from the check state. Sync active-low reset: defaults, idle.
module sun_disk_label_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_label_word,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic        out_slice_valid,
  output logic [2:0]  out_slot,
  output logic [31:0] out_start_sector,
  output logic [31:0] out_size_sectors,
  output logic [3:0]  out_slice_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sdl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  sdl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sdl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_label_word    (in_label_word),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slice_valid  (out_slice_valid),
    .out_slot         (out_slot),
    .out_start_sector (out_start_sector),
    .out_size_sectors (out_size_sectors),
    .out_slice_count  (out_slice_count),
    .out_last         (out_last)
  );

endmodule
